// ===== design/block_request_picker_assert.svh =====
// Assertion macros used by the block request picker module.
// Depends on nothing; included by files that hold concurrent checks.
`ifndef BLOCK_REQUEST_PICKER_ASSERT_SVH
`define BLOCK_REQUEST_PICKER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/brp_pkg.sv =====
// Package of the block request picker: payload structs and codes.
// Depends on nothing; used by block_request_picker.sv.
package brp_pkg;
  localparam logic [2:0] KIND_ISSUE   = 3'd0;
  localparam logic [2:0] KIND_LOAD    = 3'd1;
  localparam logic [2:0] KIND_HAVE    = 3'd2;
  localparam logic [2:0] KIND_RECV    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_RETIRE  = 3'd5;
  localparam logic [1:0] ST_ISSUED    = 2'd0;
  localparam logic [1:0] ST_NOTHING   = 2'd1;
  localparam logic [1:0] ST_REFUSED   = 2'd2;
  localparam int unsigned MAX_OUT     = 64;
  // Bytes in one block; offsets and block counts use a shift by its log2.
  localparam int unsigned BLOCK_BYTES = 16384;
  localparam logic [1:0] CFG_LINK_UP  = 2'd0;
  localparam logic [1:0] CFG_CHOKED   = 2'd1;
  localparam logic [1:0] CFG_MAX_PIPE = 2'd2;
  localparam logic [1:0] CFG_PCOUNT   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  piece_index;
    logic [5:0]  block_index;
    logic [20:0] piece_bytes;
    logic        flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  req_piece;
    logic [19:0] req_offset;
    logic [14:0] req_length;
    logic        last;
  } out_item_t;
endpackage

// ===== design/block_request_picker.sv =====
// Top level of the block request picker: tables, scan sequencer, output register.
// Depends on brp_pkg and block_request_picker_assert.svh.
//
// Usage: items enter on in_valid/in_ready (brp_pkg::in_item_t) and results
// leave on out_valid/out_ready (brp_pkg::out_item_t). Configuration is a plain
// write port (cfg_we, cfg_index, cfg_wdata); it must be written only while idle,
// which the block itself does not enforce. An event item is a memory read, then
// a write back. An issue item walks the pieces one per cycle while no hit is
// found, with a memory read per piece; each hit adds steps (write the requested
// bit once the output register is free, re-read, re-check the same piece).
// One item is in work at a time; in_ready is low meanwhile.
// After reset a clearing pass zeroes the flag memory of all NUM_PIECES pieces;
// no item is accepted during it. Per-block words and lengths are not cleared.
// A stalled receiver holds the output register; the scan waits on it.
`include "block_request_picker_assert.svh"
module block_request_picker #(
  parameter int NUM_PIECES = 1024,
  parameter int BLOCKS_PER_PIECE = 64
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  brp_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output brp_pkg::out_item_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [10:0] cfg_wdata
);
  localparam int AW = (NUM_PIECES > 1) ? $clog2(NUM_PIECES) : 1;
  localparam int BW = (BLOCKS_PER_PIECE > 1) ? $clog2(BLOCKS_PER_PIECE) : 1;
  localparam int SH = $clog2(brp_pkg::BLOCK_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0, S_IDLE = 3'd1, S_EVT = 3'd2,
    S_SCAN = 3'd3, S_HIT = 3'd4, S_EMIT = 3'd5, S_END = 3'd6;

  // Memories: flags {done,have,loaded}, length, received, requested.
  logic [2:0]  flag_mem [NUM_PIECES];
  logic [20:0] len_mem  [NUM_PIECES];
  logic [63:0] rcv_mem  [NUM_PIECES];
  logic [63:0] req_mem  [NUM_PIECES];
  logic [2:0]  flag_q;
  logic [20:0] len_q;
  logic [63:0] rcv_q, req_q;

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  brp_pkg::in_item_t item_r;
  logic link_r, choke_r;
  logic [6:0] maxp_r, outst_r, outst_nxt, nout_r, nout_nxt;
  logic [10:0] pcnt_r;
  logic ov_r, ov_nxt;
  brp_pkg::out_item_t od_r, od_nxt;
  logic [BW-1:0] hit_b_r, hit_b_nxt;

  logic rd_en, we_flag, we_len, we_rcv, we_req;
  logic [AW-1:0] rd_addr;
  logic [2:0] flag_wd;
  logic [63:0] rcv_wd, req_wd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      flag_q <= flag_mem[rd_addr];
      len_q  <= len_mem[rd_addr];
      rcv_q  <= rcv_mem[rd_addr];
      req_q  <= req_mem[rd_addr];
    end
    if (we_flag) flag_mem[addr_r] <= flag_wd;
    if (we_len) len_mem[addr_r] <= item_r.piece_bytes;
    if (we_rcv) rcv_mem[addr_r] <= rcv_wd;
    if (we_req) req_mem[addr_r] <= req_wd;
  end

  // Block count from length and first free block.
  logic [21:0] nb_raw;
  logic [6:0] nb;
  logic [63:0] free_v;
  logic found_b;
  logic [BW-1:0] fb;
  logic piece_ok, in_range;
  logic [11:0] limit;
  always_comb begin
    nb_raw = ({1'b0, len_q} + 22'(brp_pkg::BLOCK_BYTES - 1)) >> SH;
    nb = (nb_raw > 22'(BLOCKS_PER_PIECE)) ? 7'(BLOCKS_PER_PIECE) : nb_raw[6:0];
    found_b = 1'b0;
    fb = '0;
    for (int b = 0; b < 64; b++) begin
      free_v[b] = (b < BLOCKS_PER_PIECE) && (7'(b) < nb) && !rcv_q[b] && !req_q[b];
    end
    for (int b = 63; b >= 0; b--) begin
      if (free_v[b]) begin
        found_b = 1'b1;
        fb = BW'(b);
      end
    end
    piece_ok = !flag_q[2] && flag_q[1] && flag_q[0];
    limit = ({1'b0, pcnt_r} > 12'(NUM_PIECES)) ? 12'(NUM_PIECES) : {1'b0, pcnt_r};
    in_range = 12'(addr_r) < limit;
  end

  logic [19:0] off;
  logic [20:0] rem;
  assign off = 20'({14'd0, hit_b_r} << SH);
  assign rem = len_q - {1'b0, off};

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  logic out_free;
  assign out_free = !ov_r || (out_valid && out_ready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r; addr_nxt = addr_r; outst_nxt = outst_r; nout_nxt = nout_r;
    ov_nxt = ov_r && !(out_valid && out_ready); od_nxt = od_r; hit_b_nxt = hit_b_r;
    rd_en = 1'b0; rd_addr = addr_r;
    we_flag = 1'b0; we_len = 1'b0; we_rcv = 1'b0; we_req = 1'b0;
    flag_wd = flag_q; rcv_wd = rcv_q | (64'd1 << item_r.block_index); req_wd = req_q;
    unique case (state_r)
      S_CLEAR: begin
        we_flag = 1'b1; flag_wd = '0;
        addr_nxt = addr_r + 1'b1;
        if (32'(addr_r) == NUM_PIECES - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          addr_nxt = AW'(in_data.piece_index); nout_nxt = '0;
          rd_en = 1'b1; rd_addr = AW'(in_data.piece_index);
          if (in_data.kind == brp_pkg::KIND_ISSUE) begin
            addr_nxt = '0; rd_addr = '0;
            if (!link_r || choke_r) begin
              ov_nxt = 1'b1;
              od_nxt = '{brp_pkg::ST_REFUSED, 10'd0, 20'd0, 15'd0, 1'b1};
            end else state_nxt = S_SCAN;
          end else state_nxt = S_EVT;
        end
      end
      S_EVT: begin
        state_nxt = S_IDLE;
        if (32'(item_r.piece_index) < NUM_PIECES) begin
          unique case (item_r.kind)
            brp_pkg::KIND_LOAD: begin
              we_flag = 1'b1; flag_wd = {flag_q[2:1], 1'b1};
              we_len = 1'b1; we_rcv = 1'b1; rcv_wd = '0; we_req = 1'b1; req_wd = '0;
            end
            brp_pkg::KIND_HAVE: begin
              we_flag = 1'b1; flag_wd = {flag_q[2], item_r.flag, flag_q[0]};
            end
            brp_pkg::KIND_RECV: we_rcv = 32'(item_r.block_index) < BLOCKS_PER_PIECE;
            brp_pkg::KIND_DONE: begin
              we_flag = 1'b1; flag_wd = {1'b1, flag_q[1:0]};
            end
            default: ;
          endcase
        end
        if (item_r.kind == brp_pkg::KIND_RETIRE && outst_r != 0) outst_nxt = outst_r - 1'b1;
      end
      S_SCAN: begin
        // Data for addr_r is in the read registers.
        if (nout_r == 7'(brp_pkg::MAX_OUT) || outst_r >= maxp_r || !in_range) begin
          state_nxt = S_END;
        end else if (piece_ok && found_b) begin
          hit_b_nxt = fb; state_nxt = S_HIT;
        end else if (32'(addr_r) == NUM_PIECES - 1) begin
          state_nxt = S_END;
        end else begin
          addr_nxt = addr_r + 1'b1; rd_en = 1'b1; rd_addr = addr_r + 1'b1;
        end
      end
      S_HIT: begin
        if (out_free) begin
          we_req = 1'b1; req_wd = req_q | (64'd1 << hit_b_r);
          ov_nxt = 1'b1;
          od_nxt = '{brp_pkg::ST_ISSUED, 10'(addr_r), off,
                     (rem < 21'(brp_pkg::BLOCK_BYTES)) ? rem[14:0] :
                     15'(brp_pkg::BLOCK_BYTES), 1'b0};
          outst_nxt = outst_r + 1'b1; nout_nxt = nout_r + 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Re-read the same piece after the write lands.
        rd_en = 1'b1; state_nxt = S_SCAN;
      end
      S_END: begin
        if (nout_r == 0) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            od_nxt = '{brp_pkg::ST_NOTHING, 10'd0, 20'd0, 15'd0, 1'b1};
            state_nxt = S_IDLE;
          end
        end else begin
          // The held request is the final one of this item.
          if (ov_r) od_nxt.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The newest request is held while the scan may still find another one.
  logic last_fix;
  assign last_fix = (state_r == S_EMIT) || (state_r == S_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; addr_r <= '0; outst_r <= '0; nout_r <= '0; ov_r <= 1'b0;
      link_r <= 1'b0; choke_r <= 1'b1; maxp_r <= 7'd5; pcnt_r <= 11'd1;
    end else begin
      state_r <= state_nxt; addr_r <= addr_nxt; outst_r <= outst_nxt;
      nout_r <= nout_nxt; ov_r <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          brp_pkg::CFG_LINK_UP:  link_r <= cfg_wdata[0];
          brp_pkg::CFG_CHOKED:   choke_r <= cfg_wdata[0];
          brp_pkg::CFG_MAX_PIPE: maxp_r <= cfg_wdata[6:0];
          brp_pkg::CFG_PCOUNT:   pcnt_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt; hit_b_r <= hit_b_nxt;
    if (in_valid && in_ready) item_r <= in_data;
  end

  // Hold a request in the output register until the scan knows if it is final.
  // A further hit proves it is not, so it is released while the sequencer waits in S_HIT.
  logic hold_out;
  assign hold_out = last_fix || (state_r == S_END && nout_r != 0);
  assign out_valid = ov_r && !(hold_out && !od_r.last && od_r.status == brp_pkg::ST_ISSUED);
  assign out_data = od_r;

  `BRP_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `BRP_ASSERT_IMP(a_out_le_max, clk, rst_n, state_r == S_HIT, outst_r < maxp_r)
  `BRP_ASSERT_NXT(a_hit_emits, clk, rst_n, state_r == S_HIT && out_free, ov_r)
endmodule
